[hw/rtl/schematic_pixel_colorizer_assert.svh]
// Assertion macros used by the colorizer top level.
`ifndef SCHEMATIC_PIXEL_COLORIZER_ASSERT_SVH
`define SCHEMATIC_PIXEL_COLORIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SCPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SCPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/scpc_pkg.sv]
// Shared types, constants and helper functions of the pixel colorizer.
`default_nettype none

package scpc_pkg;

	localparam int SCREEN_WIDTH_MAX = 4096;
	localparam int POS_W            = $clog2(SCREEN_WIDTH_MAX);
	localparam int COORD_W          = 25;
	localparam int ZOOM_W           = 3;
	localparam int ID_W             = 32;
	localparam int PW_W             = 8;
	localparam int CH_W             = 8;
	localparam int CFG_DATA_W       = 32;
	localparam int CFG_IDX_W        = 3;

	// World coordinate of a pixel span start: origin plus position scaled by up to 8.
	localparam int SPAN_W = POS_W + 3;
	localparam int LO_W   = ((COORD_W > SPAN_W) ? COORD_W : SPAN_W) + 1;

	// floor(u / 100) = (u * RECIP_100) >> RECIP_SHIFT, exact for u below 2**30.
	localparam int                 RECIP_SHIFT = 33;
	localparam int                 RECIP_W     = 27;
	localparam logic [RECIP_W-1:0] RECIP_100   = 27'd85899346;
	localparam int                 QUO_W       = LO_W - 6;
	localparam int                 RES_W       = 7;
	// Residue of 2**LO_W modulo 100, removed again for negative coordinates.
	localparam logic [RES_W-1:0]   WRAP_RES    = RES_W'((2 ** LO_W) % 100);
	localparam logic [RES_W-1:0]   MOD_HUNDRED = 7'd100;

	// Grid spacing and major pitch for the fine (zoom 1, 2) and coarse (zoom 4, 8) grids.
	localparam logic [5:0] SP_FINE    = 6'd10;
	localparam logic [5:0] SP_COARSE  = 6'd50;
	localparam logic [6:0] MAJ_FINE   = 7'd50;
	localparam logic [6:0] MAJ_COARSE = 7'd100;

	// Power ramp: level * 255 / 50 as one constant multiply.
	localparam logic [22:0]   RAMP_MUL = 23'd5347860;
	localparam logic [PW_W-1:0] PW_SAT  = 8'd100;
	localparam logic [PW_W-1:0] PW_KNEE = 8'd50;
	localparam logic [CH_W-1:0] CH_FULL = 8'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ZOOM_LOG2  = 3'd2,
		REG_CLASS_MASK = 3'd3,
		REG_NET_TYPE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GRID_NONE,
		GRID_MINOR,
		GRID_MAJOR
	} grid_kind_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Load strobes of the internal pipeline stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} adv_t;

	localparam rgb_t RGB_MAGENTA = '{red: 8'hff, green: 8'h00, blue: 8'hff};
	localparam rgb_t RGB_BLACK   = '{red: 8'h00, green: 8'h00, blue: 8'h00};
	localparam rgb_t RGB_WHITE   = '{red: 8'hff, green: 8'hff, blue: 8'hff};
	localparam rgb_t RGB_MINOR   = '{red: 8'he0, green: 8'he0, blue: 8'hff};
	localparam rgb_t RGB_MAJOR   = '{red: 8'h80, green: 8'h80, blue: 8'hff};

	localparam logic [COORD_W-1:0] ORIGIN_RST     = '0;
	localparam logic [ZOOM_W-1:0]  ZOOM_RST       = 3'd6;
	localparam logic [ID_W-1:0]    CLASS_MASK_RST = 32'hff000000;
	localparam logic [ID_W-1:0]    NET_TYPE_RST   = 32'h80000000;

	// Channel value for a level of 0..50 along one ramp segment.
	function automatic logic [CH_W-1:0] ramp(input logic [5:0] lvl);
		logic [28:0] prod;
		prod = 29'(lvl) * 29'(RAMP_MUL);
		return prod[27:20];
	endfunction

	// Remainder by 10 of a value below 50.
	function automatic logic [3:0] mod10(input logic [5:0] v);
		logic [5:0] t;
		t = v;
		if (t >= 6'd40) begin
			t = t - 6'd40;
		end else if (t >= 6'd30) begin
			t = t - 6'd30;
		end else if (t >= 6'd20) begin
			t = t - 6'd20;
		end else if (t >= 6'd10) begin
			t = t - 6'd10;
		end
		return t[3:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/scpc_stream_if.sv]
// Request channel interfaces: pixel request in, color request out.
`default_nettype none

interface scpc_pix_in_if;
	logic                         valid;
	logic                         ready;
	logic [scpc_pkg::POS_W-1:0]   screen_x;
	logic [scpc_pkg::POS_W-1:0]   screen_y;
	logic [scpc_pkg::ID_W-1:0]    pixel_id;
	logic                         net_highlight;
	logic [scpc_pkg::PW_W-1:0]    net_power;

	modport source(output valid, screen_x, screen_y, pixel_id, net_highlight, net_power,
		input ready);
	modport sink(input valid, screen_x, screen_y, pixel_id, net_highlight, net_power,
		output ready);
endinterface

interface scpc_pix_out_if;
	logic                        valid;
	logic                        ready;
	logic [scpc_pkg::CH_W-1:0]   red;
	logic [scpc_pkg::CH_W-1:0]   green;
	logic [scpc_pkg::CH_W-1:0]   blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

[hw/rtl/scpc_grid.sv]
// One grid axis: world coordinate of the pixel span and its residue modulo 100.
`default_nettype none

module scpc_grid (
	input  wire logic                                 clk,
	input  wire logic signed [scpc_pkg::COORD_W-1:0]  origin,
	input  wire logic [1:0]                           zoom_sh,
	input  wire logic [scpc_pkg::POS_W-1:0]           pos_s1,
	input  wire scpc_pkg::adv_t                       adv,
	output logic [scpc_pkg::RES_W-1:0]                residue
);

	localparam int LO_W   = scpc_pkg::LO_W;
	localparam int PROD_W = LO_W + scpc_pkg::RECIP_W;
	localparam int RES_W  = scpc_pkg::RES_W;

	logic [LO_W-1:0]        span_c;
	logic [LO_W-1:0]        lo_c;
	logic [LO_W-1:0]        lo_s2;
	logic [PROD_W-1:0]      prod_c;
	logic [RES_W-1:0]       quo_s3;
	logic [RES_W-1:0]       low_s3;
	logic                   neg_s3;
	logic [2*RES_W-1:0]     quo100;
	logic [RES_W-1:0]       raw_res;

	// Span start: origin plus column (or row) times the zoom factor.
	assign span_c = LO_W'(pos_s1) << zoom_sh;
	assign lo_c   = LO_W'(origin) + span_c;

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			lo_s2 <= lo_c;
		end
	end

	// Quotient by 100 of the unsigned bit pattern; only its low bits matter afterward.
	assign prod_c = PROD_W'(lo_s2) * PROD_W'(scpc_pkg::RECIP_100);

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			quo_s3 <= prod_c[scpc_pkg::RECIP_SHIFT +: RES_W];
			low_s3 <= lo_s2[RES_W-1:0];
			neg_s3 <= lo_s2[LO_W-1];
		end
	end

	// Remainder fits in seven bits, so seven-bit arithmetic is exact.
	assign quo100  = (2*RES_W)'(quo_s3) * (2*RES_W)'(scpc_pkg::MOD_HUNDRED);
	assign raw_res = low_s3 - quo100[RES_W-1:0];

	// Negative coordinate: drop the 2**LO_W bias, wrapping inside 0..99.
	always_comb begin
		residue = raw_res;
		if (neg_s3) begin
			if (raw_res >= scpc_pkg::WRAP_RES) begin
				residue = raw_res - scpc_pkg::WRAP_RES;
			end else begin
				residue = raw_res + (scpc_pkg::MOD_HUNDRED - scpc_pkg::WRAP_RES);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/scpc_shade.sv]
// Final color choice: grid line classification for empty pixels.
`default_nettype none

module scpc_shade (
	input  wire logic [scpc_pkg::ZOOM_W-1:0]  zoom,
	input  wire logic [scpc_pkg::RES_W-1:0]   res_x,
	input  wire logic [scpc_pkg::RES_W-1:0]   res_y,
	input  wire logic                         empty,
	input  wire scpc_pkg::rgb_t               fill,
	output scpc_pkg::rgb_t                    color
);

	function automatic scpc_pkg::grid_kind_t axis_kind(input logic [6:0] r100,
		input logic [1:0] zsh);
		logic [5:0] r50;
		logic [5:0] m;
		logic [5:0] off;
		logic [5:0] sp;
		logic [6:0] base;
		logic [6:0] mjr;
		logic [7:0] sum;
		logic [3:0] zmax;
		r50 = (r100 >= 7'd50) ? 6'(r100 - 7'd50) : r100[5:0];
		if (!zsh[1]) begin
			m    = 6'(scpc_pkg::mod10(r50));
			base = 7'(r50);
			sp   = scpc_pkg::SP_FINE;
			mjr  = scpc_pkg::MAJ_FINE;
		end else begin
			m    = r50;
			base = r100;
			sp   = scpc_pkg::SP_COARSE;
			mjr  = scpc_pkg::MAJ_COARSE;
		end
		// Distance up to the next line; the span covers 2**zsh units.
		off  = (m == 6'd0) ? 6'd0 : sp - m;
		zmax = (4'd1 << zsh) - 4'd1;
		sum  = 8'(base) + 8'(off);
		if (off > 6'(zmax)) begin
			return scpc_pkg::GRID_NONE;
		end else if (sum == 8'd0 || sum == 8'(mjr)) begin
			return scpc_pkg::GRID_MAJOR;
		end
		return scpc_pkg::GRID_MINOR;
	endfunction

	scpc_pkg::grid_kind_t kind_x;
	scpc_pkg::grid_kind_t kind_y;
	scpc_pkg::grid_kind_t kind;

	assign kind_x = axis_kind(res_x, zoom[1:0]);
	assign kind_y = axis_kind(res_y, zoom[1:0]);

	// Vertical line wins at crossings; no grid at zoom 16 and beyond.
	always_comb begin
		kind = scpc_pkg::GRID_NONE;
		if (!zoom[2]) begin
			kind = (kind_x != scpc_pkg::GRID_NONE) ? kind_x : kind_y;
		end
	end

	always_comb begin
		color = fill;
		if (empty) begin
			case (kind)
				scpc_pkg::GRID_MINOR: color = scpc_pkg::RGB_MINOR;
				scpc_pkg::GRID_MAJOR: color = scpc_pkg::RGB_MAJOR;
				default:              color = scpc_pkg::RGB_WHITE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/schematic_pixel_colorizer.sv]
// Top level of the schematic pixel colorizer: config registers, pipeline and handshake.
//
//  channel   | dir | payload                                            | handshake
//  ----------+-----+----------------------------------------------------+-------------
//  pix_in    | in  | screen_x, screen_y, pixel_id, net_highlight, power | valid/ready
//  pix_out   | out | red, green, blue                                   | valid/ready
//  cfg       | in  | cfg_index, cfg_wdata                               | cfg_wen only
//
// Throughput is one pixel request per cycle while pix_out takes colors; a request
// passes stages s1, s2, s3 and s4 before pix_out.valid. Depth is set by the
// residue-by-100 path of the grid: span add, reciprocal multiply, then the
// remainder and color choice. Every stage has its own valid bit and ready, so
// bubbles collapse and a new request enters while a finished color waits on pix_out.
// arst_n clears the valid bits and the config registers to their defaults.
`default_nettype none

module schematic_pixel_colorizer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [scpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [scpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	scpc_pix_in_if.sink                              pix_in,
	scpc_pix_out_if.source                           pix_out
);

`include "schematic_pixel_colorizer_assert.svh"

	// Configuration registers
	logic signed [scpc_pkg::COORD_W-1:0] origin_x_q;
	logic signed [scpc_pkg::COORD_W-1:0] origin_y_q;
	logic [scpc_pkg::ZOOM_W-1:0]         zoom_q;
	logic [scpc_pkg::ID_W-1:0]           class_mask_q;
	logic [scpc_pkg::ID_W-1:0]           net_type_q;

	// Pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	scpc_pkg::adv_t adv;

	// Stage 1: captured request
	logic [scpc_pkg::POS_W-1:0] sx_s1;
	logic [scpc_pkg::POS_W-1:0] sy_s1;
	logic [scpc_pkg::ID_W-1:0]  id_s1;
	logic                       hl_s1;
	logic [scpc_pkg::PW_W-1:0]  pw_s1;

	// Stage 2 and 3: object color and empty flag ride along with the grid math
	scpc_pkg::rgb_t fill_c;
	logic           empty_c;
	scpc_pkg::rgb_t fill_s2;
	logic           empty_s2;
	scpc_pkg::rgb_t fill_s3;
	logic           empty_s3;

	logic [6:0]     pw_clip;
	logic           is_net;

	logic [scpc_pkg::RES_W-1:0] res_x;
	logic [scpc_pkg::RES_W-1:0] res_y;
	scpc_pkg::rgb_t             color_c;
	scpc_pkg::rgb_t             rgb_s4;

	// Register file: write only, taken whenever cfg_wen is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= scpc_pkg::ORIGIN_RST;
			origin_y_q   <= scpc_pkg::ORIGIN_RST;
			zoom_q       <= scpc_pkg::ZOOM_RST;
			class_mask_q <= scpc_pkg::CLASS_MASK_RST;
			net_type_q   <= scpc_pkg::NET_TYPE_RST;
		end else if (cfg_wen) begin
			unique case (scpc_pkg::cfg_reg_t'(cfg_index))
				scpc_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_wdata[scpc_pkg::COORD_W-1:0];
				scpc_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_wdata[scpc_pkg::COORD_W-1:0];
				scpc_pkg::REG_ZOOM_LOG2:  zoom_q       <= cfg_wdata[scpc_pkg::ZOOM_W-1:0];
				scpc_pkg::REG_CLASS_MASK: class_mask_q <= cfg_wdata;
				scpc_pkg::REG_NET_TYPE:   net_type_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Ready chain: a stage takes a new request when empty or when it drains this cycle.
	assign rdy_s4 = !vld_s4 || pix_out.ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign pix_in.ready = rdy_s1;

	assign adv.ld_s2 = rdy_s2;
	assign adv.ld_s3 = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= pix_in.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Capture the request; payload needs no reset.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sx_s1 <= pix_in.screen_x;
			sy_s1 <= pix_in.screen_y;
			id_s1 <= pix_in.pixel_id;
			hl_s1 <= pix_in.net_highlight;
			pw_s1 <= pix_in.net_power;
		end
	end

	// Object color. The net test comes first, so a zero id can still count as a net.
	assign is_net  = (id_s1 & class_mask_q) == net_type_q;
	assign pw_clip = (pw_s1 > scpc_pkg::PW_SAT) ? 7'(scpc_pkg::PW_SAT) : pw_s1[6:0];

	always_comb begin
		fill_c  = scpc_pkg::RGB_BLACK;
		empty_c = 1'b0;
		if (is_net) begin
			if (hl_s1) begin
				fill_c = scpc_pkg::RGB_MAGENTA;
			end else if (pw_clip <= 7'(scpc_pkg::PW_KNEE)) begin
				// Black to red
				fill_c.red = scpc_pkg::ramp(6'(pw_clip));
			end else begin
				// Red to yellow
				fill_c.red   = scpc_pkg::CH_FULL;
				fill_c.green = scpc_pkg::ramp(6'(pw_clip - 7'(scpc_pkg::PW_KNEE)));
			end
		end else if (id_s1 == '0) begin
			empty_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			fill_s2  <= fill_c;
			empty_s2 <= empty_c;
		end
		if (rdy_s3) begin
			fill_s3  <= fill_s2;
			empty_s3 <= empty_s2;
		end
	end

	// Grid residues for both axes, aligned with stage 3.
	scpc_grid u_grid_x (
		.clk     (clk),
		.origin  (origin_x_q),
		.zoom_sh (zoom_q[1:0]),
		.pos_s1  (sx_s1),
		.adv     (adv),
		.residue (res_x)
	);

	scpc_grid u_grid_y (
		.clk     (clk),
		.origin  (origin_y_q),
		.zoom_sh (zoom_q[1:0]),
		.pos_s1  (sy_s1),
		.adv     (adv),
		.residue (res_y)
	);

	scpc_shade u_shade (
		.zoom  (zoom_q),
		.res_x (res_x),
		.res_y (res_y),
		.empty (empty_s3),
		.fill  (fill_s3),
		.color (color_c)
	);

	// Output register: hold while pix_out stalls.
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			rgb_s4 <= color_c;
		end
	end

	assign pix_out.valid = vld_s4;
	assign pix_out.red   = rgb_s4.red;
	assign pix_out.green = rgb_s4.green;
	assign pix_out.blue  = rgb_s4.blue;

	`SCPC_ASSERT_NEXT(a_accept_fills_s1, pix_in.valid && pix_in.ready, vld_s1,
		"accepted request did not reach stage 1")
	`SCPC_ASSERT_NOW(a_bubble_takes_request, !vld_s1, pix_in.ready,
		"empty stage 1 but request refused")
	`SCPC_ASSERT_NEXT(a_s3_held_on_stall, vld_s3 && !rdy_s4, vld_s3,
		"stage 3 request lost while output stalled")

endmodule

`default_nettype wire
